@@ rtl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define ASSERT_IMPLIES(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("allocator assertion failed");

// Checks that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("allocator assertion failed");

`endif

@@ rtl/pba_pkg.sv @@
// Shared types, constants and helpers of the paged bump allocator.
// Depends on nothing; used by every allocator module but pba_ram.
package pba_pkg;

  localparam int NUM_PAGES = 64;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);
  localparam int FENCE_W   = 48;
  localparam int SIZE_W    = 24;
  localparam int PSIZE_W   = 25;
  localparam int ALIGN_W   = 5;
  localparam int WIDE_W    = 32;
  localparam int IDX_OUT_W = 6;
  localparam int STATUS_W  = 2;

  localparam logic [0:0] REQ_ALLOC   = 1'b0;
  localparam logic [0:0] REQ_CLEANUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LARGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOPAGE = 2'd2;

  // A classified request as it leaves the front end.
  typedef struct packed {
    logic [0:0]          req_type;
    logic [WIDE_W-1:0]   amask;
    logic [WIDE_W-1:0]   aligned;
    logic [SIZE_W-1:0]   granted;
    logic                oversize;
    logic [FENCE_W-1:0]  fence;
    logic [FENCE_W-1:0]  completed;
  } item_t;

  // One result as driven towards the ports.
  typedef struct packed {
    logic                 valid;
    logic [IDX_OUT_W-1:0] page;
    logic [SIZE_W-1:0]    offset;
    logic [SIZE_W-1:0]    granted;
    logic [STATUS_W-1:0]  status;
  } result_t;

  // Ring slot that lies n places after head.
  function automatic logic [PAGE_W-1:0] slot_after(input logic [PAGE_W-1:0] head,
                                                   input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(n);
    if (s >= (CNT_W + 1)'(NUM_PAGES)) begin
      s = s - (CNT_W + 1)'(NUM_PAGES);
    end
    return s[PAGE_W-1:0];
  endfunction

endpackage

@@ rtl/paged_bump_allocator_fence_recycle.sv @@
// Top level of the paged bump allocator with fence-based page recycling.
// Depends on pba_pkg, pba_front, pba_queue, pba_back and assert_macros.svh.
//
// A request is taken when start is high and busy is low; its one result appears
// on the result ports for a single cycle with done high and cannot be held off,
// so the receiver must take it then. Requests are handled one at a time: for an
// allocation that fits the current page or is flagged large, done rises once the
// request has passed the front-end register, the queue and the back-end execute
// state, and busy is already low while done is high, so the next such request can
// be issued then. Needing a new page first moves each completed retired page to
// the free FIFO, then takes a page from the free FIFO or mints a new one if any is
// left; a cleanup moves each pending page and then the current page, if any, to
// the retired list. Each page store has a registered read port.
// page_size may be written whenever busy is low.
`include "assert_macros.svh"
module paged_bump_allocator_fence_recycle (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [0:0]                    req_type,
  input  logic [pba_pkg::SIZE_W-1:0]    alloc_size,
  input  logic [pba_pkg::ALIGN_W-1:0]   align_log2,
  input  logic [pba_pkg::FENCE_W-1:0]   fence_value,
  input  logic [pba_pkg::FENCE_W-1:0]   completed_fence,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pba_pkg::PSIZE_W-1:0]   cfg_data,
  output logic                          done,
  output logic [pba_pkg::IDX_OUT_W-1:0] page_index,
  output logic [pba_pkg::SIZE_W-1:0]    byte_offset,
  output logic [pba_pkg::SIZE_W-1:0]    granted_size,
  output logic [pba_pkg::STATUS_W-1:0]  status
);
  import pba_pkg::*;

  logic [PSIZE_W-1:0] page_size;
  logic               accept;
  logic               push;
  logic               q_full;
  logic               q_not_empty;
  logic               pop;
  logic               back_active;
  item_t              front_item;
  item_t              q_item;
  result_t            res;
  logic               front_held;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Page size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= PSIZE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      page_size <= cfg_data;
    end
  end

  // Tracks a request sitting in the front-end register.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_held <= 1'b0;
    end else if (accept) begin
      front_held <= 1'b1;
    end else if (push) begin
      front_held <= 1'b0;
    end
  end

  assign busy = front_held || q_not_empty || back_active;

  pba_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .req_type(req_type),
    .alloc_size(alloc_size), .align_log2(align_log2), .fence_value(fence_value),
    .completed_fence(completed_fence), .page_size(page_size), .q_full(q_full),
    .push(push), .item(front_item)
  );

  pba_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(front_item), .pop(pop),
    .full(q_full), .not_empty(q_not_empty), .head_item(q_item)
  );

  pba_back u_back (
    .clk(clk), .rst(rst), .page_size(page_size), .q_not_empty(q_not_empty),
    .q_item(q_item), .pop(pop), .active(back_active), .res(res)
  );

  assign done         = res.valid;
  assign page_index   = res.page;
  assign byte_offset  = res.offset;
  assign granted_size = res.granted;
  assign status       = res.status;

  // A result only follows a request still in flight and lasts a single cycle;
  // an accepted request keeps busy high in the following cycle.
  `ASSERT_IMPLIES(a_done_after_busy, clk, rst, done, $past(busy))
  `ASSERT_NEXT(a_accept_sets_busy, clk, rst, accept, busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

@@ rtl/pba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for every list and FIFO store of the allocator.
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pba_front.sv @@
// Front end: takes a request, rounds the size to its alignment and flags large ones.
// Depends on pba_pkg.
module pba_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [0:0]                    req_type,
  input  logic [pba_pkg::SIZE_W-1:0]    alloc_size,
  input  logic [pba_pkg::ALIGN_W-1:0]   align_log2,
  input  logic [pba_pkg::FENCE_W-1:0]   fence_value,
  input  logic [pba_pkg::FENCE_W-1:0]   completed_fence,
  input  logic [pba_pkg::PSIZE_W-1:0]   page_size,
  input  logic                          q_full,
  output logic                          push,
  output pba_pkg::item_t                item
);
  import pba_pkg::*;

  logic              held;
  logic [WIDE_W-1:0] amask;
  logic [WIDE_W-1:0] aligned;

  // Alignment mask and rounded size.
  always_comb begin
    amask   = (WIDE_W'(1) << align_log2) - WIDE_W'(1);
    aligned = (WIDE_W'(alloc_size) + amask) & ~amask;
  end

  assign push = held && !q_full;

  // Capture the classified request until the queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (accept) begin
      item.req_type  <= req_type;
      item.amask     <= amask;
      item.aligned   <= aligned;
      item.granted   <= (aligned > WIDE_W'(24'hFF_FFFF)) ? 24'hFF_FFFF
                                                         : aligned[SIZE_W-1:0];
      item.oversize  <= aligned > WIDE_W'(page_size);
      item.fence     <= fence_value;
      item.completed <= completed_fence;
    end
  end

endmodule

@@ rtl/pba_queue.sv @@
// Two-entry queue of classified requests between front and back ends.
// Depends on pba_pkg.
module pba_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pba_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output pba_pkg::item_t head_item
);
  import pba_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head_item = slots[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/pba_back.sv @@
// Back end: bumps the current page, keeps the pending list and both page FIFOs.
// Depends on pba_pkg, pba_ram and assert_macros.svh.
`include "assert_macros.svh"
module pba_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pba_pkg::PSIZE_W-1:0]  page_size,
  input  logic                         q_not_empty,
  input  pba_pkg::item_t               q_item,
  output logic                         pop,
  output logic                         active,
  output pba_pkg::result_t             res
);
  import pba_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_CL_REQ  = 9'b000000100,
    S_CL_WR   = 9'b000001000,
    S_CL_CUR  = 9'b000010000,
    S_DR_REQ  = 9'b000100000,
    S_DR_CHK  = 9'b001000000,
    S_FR_REQ  = 9'b010000000,
    S_FR_TAKE = 9'b100000000
  } state_t;

  localparam int RET_W = FENCE_W + PAGE_W;

  state_t              state;
  item_t               it;
  logic                cur_valid;
  logic [PAGE_W-1:0]   cur_page;
  logic [PSIZE_W-1:0]  cur_off;
  logic [CNT_W-1:0]    pend_count;
  logic [PAGE_W-1:0]   ret_head;
  logic [CNT_W-1:0]    ret_count;
  logic [PAGE_W-1:0]   free_head;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    minted;
  logic [PAGE_W-1:0]   idx;

  logic                pend_we;
  logic [PAGE_W-1:0]   pend_waddr;
  logic [PAGE_W-1:0]   pend_rdata;
  logic                ret_we;
  logic [RET_W-1:0]    ret_wdata;
  logic [RET_W-1:0]    ret_rdata;
  logic                free_we;
  logic [PAGE_W-1:0]   free_rdata;

  logic [WIDE_W:0]     amask33;
  logic [WIDE_W:0]     off33;
  logic [WIDE_W+1:0]   need34;
  logic                fits;
  logic                ret_le;
  logic                pend_room;
  logic                ret_room;
  logic                free_room;
  logic                finish;
  logic [CNT_W+1:0]    pages_held;

  assign pop    = (state == S_IDLE) && q_not_empty;
  assign active = state != S_IDLE;

  // Aligned offset in the current page and whether the request fits there.
  always_comb begin
    amask33   = (WIDE_W + 1)'(it.amask);
    off33     = ((WIDE_W + 1)'(cur_off) + amask33) & ~amask33;
    need34    = (WIDE_W + 2)'(off33) + (WIDE_W + 2)'(it.aligned);
    fits      = need34 <= (WIDE_W + 2)'(page_size);
    ret_le    = ret_rdata[RET_W-1:PAGE_W] <= it.completed;
    pend_room = pend_count < CNT_W'(NUM_PAGES);
    ret_room  = ret_count < CNT_W'(NUM_PAGES);
    free_room = free_count < CNT_W'(NUM_PAGES);
  end

  // States in which the request's result is issued.
  always_comb begin
    finish = ((state == S_EXEC) && (it.req_type == REQ_ALLOC) &&
              (it.oversize || (cur_valid && fits))) ||
             (state == S_CL_CUR) ||
             ((state == S_FR_REQ) && (free_count == '0)) ||
             (state == S_FR_TAKE);
  end

  // Store write controls.
  always_comb begin
    pend_we    = (state == S_EXEC) && (it.req_type == REQ_ALLOC) && !it.oversize &&
                 !fits && cur_valid && pend_room;
    pend_waddr = pend_count[PAGE_W-1:0];
    ret_we     = ((state == S_CL_WR) || ((state == S_CL_CUR) && cur_valid)) && ret_room;
    ret_wdata  = (state == S_CL_WR) ? {it.fence, pend_rdata} : {it.fence, cur_page};
    free_we    = (state == S_DR_CHK) && ret_le && free_room;
  end

  pba_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(cur_page),
    .raddr(idx), .rdata(pend_rdata)
  );

  pba_ram #(.WIDTH(RET_W), .DEPTH(NUM_PAGES)) u_ret_ram (
    .clk(clk), .we(ret_we), .waddr(slot_after(ret_head, ret_count)),
    .wdata(ret_wdata), .raddr(ret_head), .rdata(ret_rdata)
  );

  pba_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(slot_after(free_head, free_count)),
    .wdata(ret_rdata[PAGE_W-1:0]), .raddr(free_head), .rdata(free_rdata)
  );

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_valid  <= 1'b0;
      cur_page   <= '0;
      cur_off    <= '0;
      pend_count <= '0;
      ret_head   <= '0;
      ret_count  <= '0;
      free_head  <= '0;
      free_count <= '0;
      minted     <= '0;
      idx        <= '0;
      res.valid  <= 1'b0;
    end else begin
      res.valid <= finish;
      case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            it    <= q_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res.granted <= (it.req_type == REQ_CLEANUP) ? '0 : it.granted;
          if (it.req_type == REQ_CLEANUP) begin
            res.page   <= '0;
            res.offset <= '0;
            idx        <= '0;
            state      <= (pend_count != '0) ? S_CL_REQ : S_CL_CUR;
          end else if (it.oversize) begin
            res.page   <= '0;
            res.offset <= '0;
            res.status <= ST_LARGE;
            state      <= S_IDLE;
          end else if (cur_valid && fits) begin
            res.status <= ST_OK;
            res.page   <= IDX_OUT_W'(cur_page);
            res.offset <= off33[SIZE_W-1:0];
            cur_off    <= need34[PSIZE_W-1:0];
            state      <= S_IDLE;
          end else begin
            res.page   <= '0;
            res.offset <= '0;
            if (pend_we) begin
              pend_count <= pend_count + CNT_W'(1);
            end
            cur_valid <= 1'b0;
            state     <= S_DR_REQ;
          end
        end
        S_CL_REQ: begin
          state <= S_CL_WR;
        end
        S_CL_WR: begin
          if (ret_we) begin
            ret_count <= ret_count + CNT_W'(1);
          end
          if (CNT_W'(idx) + CNT_W'(1) < pend_count) begin
            idx   <= idx + PAGE_W'(1);
            state <= S_CL_REQ;
          end else begin
            state <= S_CL_CUR;
          end
        end
        S_CL_CUR: begin
          if (ret_we) begin
            ret_count <= ret_count + CNT_W'(1);
          end
          pend_count <= '0;
          cur_valid  <= 1'b0;
          cur_off    <= '0;
          res.status <= ST_OK;
          state      <= S_IDLE;
        end
        S_DR_REQ: begin
          state <= (ret_count != '0) ? S_DR_CHK : S_FR_REQ;
        end
        S_DR_CHK: begin
          if (ret_le) begin
            if (free_we) begin
              free_count <= free_count + CNT_W'(1);
            end
            ret_head  <= slot_after(ret_head, CNT_W'(1));
            ret_count <= ret_count - CNT_W'(1);
            state     <= S_DR_REQ;
          end else begin
            state <= S_FR_REQ;
          end
        end
        S_FR_REQ: begin
          if (free_count != '0) begin
            state <= S_FR_TAKE;
          end else if (minted < CNT_W'(NUM_PAGES)) begin
            cur_page   <= minted[PAGE_W-1:0];
            cur_valid  <= 1'b1;
            cur_off    <= it.aligned[PSIZE_W-1:0];
            minted     <= minted + CNT_W'(1);
            res.status <= ST_OK;
            res.page   <= IDX_OUT_W'(minted[PAGE_W-1:0]);
            state      <= S_IDLE;
          end else begin
            cur_off    <= '0;
            res.status <= ST_NOPAGE;
            state      <= S_IDLE;
          end
        end
        S_FR_TAKE: begin
          cur_page   <= free_rdata;
          cur_valid  <= 1'b1;
          cur_off    <= it.aligned[PSIZE_W-1:0];
          free_head  <= slot_after(free_head, CNT_W'(1));
          free_count <= free_count - CNT_W'(1);
          res.status <= ST_OK;
          res.page   <= IDX_OUT_W'(free_rdata);
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pages held in the current slot and the three stores.
  assign pages_held = (CNT_W + 2)'(pend_count) + (CNT_W + 2)'(ret_count) +
                      (CNT_W + 2)'(free_count) + (CNT_W + 2)'(cur_valid);

  // Every page in a store was minted once; no page is counted twice.
  `ASSERT_IMPLIES(a_free_le_minted, clk, rst, 1'b1, free_count <= minted)
  `ASSERT_IMPLIES(a_pages_conserved, clk, rst, state == S_IDLE, pages_held <= (CNT_W + 2)'(minted))
  `ASSERT_NEXT(a_pop_starts_exec, clk, rst, pop, state == S_EXEC)

endmodule
